// ===== src/fma_pkg.sv =====
// ----------------------------------------------------------------------------
// fma_pkg
// shared codes for the frontal matrix assembly block
// ----------------------------------------------------------------------------
package fma_pkg;

  typedef enum logic [2:0] {
    FN_LOAD    = 3'd0,
    FN_SCATTER = 3'd1,
    FN_CONTRIB = 3'd2,
    FN_READ    = 3'd3,
    FN_CLEAR   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXTENDED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_PIVOT_COLS  = 1'b1
  } cfg_index_t;

  localparam int KEY_W = 31;
  localparam int VAL_W = 64;

  localparam logic [10:0] EXP_MAX     = 11'h7ff;
  localparam logic [63:0] DEFAULT_NAN = 64'hfff8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

endpackage

// ===== src/fma_ram.sv =====
// ----------------------------------------------------------------------------
// fma_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fma_fpadd.sv =====
// ----------------------------------------------------------------------------
// fma_fpadd
// multi-cycle ieee double adder, round to nearest even
// ----------------------------------------------------------------------------
module fma_fpadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] sum
);

  typedef enum logic [2:0] {
    A_IDLE, A_ALIGN, A_ADD, A_NORM, A_ROUND
  } add_state_t;

  add_state_t  state;
  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [55:0] mx;
  logic [55:0] my;
  logic [56:0] s;
  logic [11:0] e;
  logic        sign;
  logic        sub;

  logic [10:0] ea, eb, ea_eff, eb_eff, ebig, esml;
  logic [55:0] ma, mb, mbig, msml, shifted;
  logic        nan_a, nan_b, inf_a, inf_b, a_big, lost;
  logic [10:0] d;

  logic [55:0] m;
  logic        up;
  logic [53:0] mant;
  logic [11:0] er;
  logic [52:0] mfin;
  logic [10:0] expf;

  always_comb begin
    ea     = op_a[62:52];
    eb     = op_b[62:52];
    ea_eff = (ea == 11'd0) ? 11'd1 : ea;
    eb_eff = (eb == 11'd0) ? 11'd1 : eb;
    ma     = {(ea != 11'd0), op_a[51:0], 3'b000};
    mb     = {(eb != 11'd0), op_b[51:0], 3'b000};
    nan_a  = (ea == fma_pkg::EXP_MAX) && (op_a[51:0] != 52'd0);
    nan_b  = (eb == fma_pkg::EXP_MAX) && (op_b[51:0] != 52'd0);
    inf_a  = (ea == fma_pkg::EXP_MAX) && (op_a[51:0] == 52'd0);
    inf_b  = (eb == fma_pkg::EXP_MAX) && (op_b[51:0] == 52'd0);
    a_big  = op_a[62:0] >= op_b[62:0];
    ebig   = a_big ? ea_eff : eb_eff;
    esml   = a_big ? eb_eff : ea_eff;
    mbig   = a_big ? ma : mb;
    msml   = a_big ? mb : ma;
    d      = ebig - esml;
    if (d >= 11'd56) begin
      shifted = 56'd0;
      lost    = (msml != 56'd0);
    end else begin
      shifted = msml >> d;
      lost    = ((shifted << d) != msml);
    end
  end

  always_comb begin
    m    = s[55:0];
    up   = m[2] & (m[1] | m[0] | m[3]);
    mant = {1'b0, m[55:3]} + 54'(up);
    if (mant[53]) begin
      er   = e + 12'd1;
      mfin = mant[53:1];
    end else begin
      er   = e;
      mfin = mant[52:0];
    end
    expf = mfin[52] ? er[10:0] : 11'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op_a  <= a;
            op_b  <= b;
            state <= A_ALIGN;
          end
        end
        A_ALIGN: begin
          priority if (nan_a) begin
            sum <= op_a | fma_pkg::QUIET_BIT;
            done <= 1'b1;
            state <= A_IDLE;
          end else if (nan_b) begin
            sum <= op_b | fma_pkg::QUIET_BIT;
            done <= 1'b1;
            state <= A_IDLE;
          end else if (inf_a && inf_b && (op_a[63] != op_b[63])) begin
            sum <= fma_pkg::DEFAULT_NAN;
            done <= 1'b1;
            state <= A_IDLE;
          end else if (inf_a) begin
            sum <= op_a;
            done <= 1'b1;
            state <= A_IDLE;
          end else if (inf_b) begin
            sum <= op_b;
            done <= 1'b1;
            state <= A_IDLE;
          end else begin
            mx    <= mbig;
            my    <= shifted | 56'(lost);
            e     <= {1'b0, ebig};
            sign  <= a_big ? op_a[63] : op_b[63];
            sub   <= op_a[63] ^ op_b[63];
            state <= A_ADD;
          end
        end
        A_ADD: begin
          s     <= sub ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
          state <= A_NORM;
        end
        A_NORM: begin
          priority if (s[56]) begin
            s     <= {1'b0, s[56:2], s[1] | s[0]};
            e     <= e + 12'd1;
            state <= A_ROUND;
          end else if (s == 57'd0) begin
            sum   <= {sign & ~sub, 63'd0};
            done  <= 1'b1;
            state <= A_IDLE;
          end else if (!s[55] && (e > 12'd1)) begin
            if ((s[55:48] == 8'd0) && (e > 12'd8)) begin
              s <= s << 8;
              e <= e - 12'd8;
            end else begin
              s <= s << 1;
              e <= e - 12'd1;
            end
          end else begin
            state <= A_ROUND;
          end
        end
        A_ROUND: begin
          if (er >= 12'd2047) begin
            sum <= {sign, fma_pkg::EXP_MAX, 52'd0};
          end else begin
            sum <= {sign, expf, mfin[51:0]};
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

// ===== src/frontal_matrix_assembly_top.sv =====
// ----------------------------------------------------------------------------
// frontal_matrix_assembly_top
// frontal matrix store with sorted row key table for multifrontal extend-add
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. A load, a read out
// of range or an unused func is answered without the value ram; a read passes
// the registered read of the value ram; a contribution add does the same, then
// waits on the multi-cycle double adder (alignment, add, normalization at up
// to 8 bits per cycle, rounding); a scatter first runs a binary search over
// the key ram and a final key compare, then adds as a contribution does. After
// reset, and for a clear, all FRONT_ROWS*MAX_PIVOT_COLS entries of the value
// store (2048 by default) are swept to zero one entry per cycle, and no item
// is taken meanwhile. A finished result waits in an output register while the
// next item is accepted.
module frontal_matrix_assembly_top #(
  parameter int FRONT_ROWS     = 64,
  parameter int MAX_PIVOT_COLS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // row_pos, col_pos, search_key, value, zero pad
  input  logic [2:0]   s_tuser,   // func
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // read_value
  output logic [1:0]   m_tuser,   // status
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int RA_W  = (FRONT_ROWS > 1) ? $clog2(FRONT_ROWS) : 1;
  localparam int CNT_W = ($clog2(FRONT_ROWS + 1) > 7) ? $clog2(FRONT_ROWS + 1) : 7;
  localparam int CC_W  = ($clog2(MAX_PIVOT_COLS + 1) > 6) ? $clog2(MAX_PIVOT_COLS + 1) : 6;
  localparam int CA_W  = (MAX_PIVOT_COLS > 1) ? $clog2(MAX_PIVOT_COLS) : 1;
  localparam int DEPTH = FRONT_ROWS * MAX_PIVOT_COLS;
  localparam int VA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLR_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] ROWS_MAX = CNT_W'(FRONT_ROWS);
  localparam logic [CC_W-1:0]  COLS_MAX = CC_W'(MAX_PIVOT_COLS);
  localparam logic [CLR_W-1:0] CLR_END  = CLR_W'(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SRCH, S_CHK, S_VRD, S_VDATA, S_ADD, S_DONE
  } state_t;

  state_t     state;
  logic [6:0] rows_in_use;
  logic [5:0] col_limit;

  logic [2:0]  in_func;
  logic [5:0]  in_row;
  logic [5:0]  in_col;
  logic [30:0] in_key;
  logic [63:0] in_value;

  logic [CNT_W-1:0] nrows, row_ext, first, count, step, probe, first_next, count_next;
  logic [CNT_W-1:0] key_rd_next, half_n;
  logic [CC_W-1:0]  ncols, col_ext;
  logic             lt;

  logic [2:0]       func;
  logic [30:0]      srch_key;
  logic [63:0]      add_value;
  logic             last;
  logic [RA_W-1:0]  val_row;
  logic [CA_W-1:0]  val_col;
  logic [CLR_W-1:0] clr_cnt;
  logic             clr_reply;
  logic [63:0]      res_value;
  logic [1:0]       res_status;

  logic            key_we;
  logic [RA_W-1:0] key_waddr, key_raddr;
  logic [30:0]     key_rdata;
  logic            val_we;
  logic [VA_W-1:0] val_addr, val_waddr;
  logic [63:0]     val_wdata, val_rdata;
  logic            add_start, add_done;
  logic [63:0]     add_sum;
  logic            accept;

  assign in_func   = s_tuser;
  assign in_row    = s_tdata[5:0];
  assign in_col    = s_tdata[11:6];
  assign in_key    = s_tdata[42:12];
  assign in_value  = s_tdata[106:43];
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign nrows   = (CNT_W'(rows_in_use) > ROWS_MAX) ? ROWS_MAX : CNT_W'(rows_in_use);
  assign ncols   = (CC_W'(col_limit) > COLS_MAX) ? COLS_MAX : CC_W'(col_limit);
  assign row_ext = CNT_W'(in_row);
  assign col_ext = CC_W'(in_col);
  assign half_n  = nrows >> 1;

  assign step       = count >> 1;
  assign probe      = first + step;
  assign lt         = key_rdata < srch_key;
  assign first_next = lt ? probe + CNT_W'(1) : first;
  assign count_next = lt ? count - step - CNT_W'(1) : step;
  assign key_rd_next = first_next + (count_next >> 1);

  always_comb begin
    key_raddr = key_rd_next[RA_W-1:0];
    if (state == S_IDLE) begin
      key_raddr = half_n[RA_W-1:0];
    end
  end

  assign key_we    = accept && (in_func == fma_pkg::FN_LOAD) && (row_ext < ROWS_MAX);
  assign key_waddr = row_ext[RA_W-1:0];

  assign val_addr  = VA_W'(val_row) * VA_W'(MAX_PIVOT_COLS) + VA_W'(val_col);
  assign add_start = (state == S_VDATA) && (func != fma_pkg::FN_READ);
  assign val_we    = ((state == S_ADD) && add_done) || (state == S_CLEAR);
  assign val_waddr = (state == S_CLEAR) ? clr_cnt[VA_W-1:0] : val_addr;
  assign val_wdata = (state == S_CLEAR) ? 64'd0 : add_sum;

  fma_ram #(.WIDTH(fma_pkg::KEY_W), .DEPTH(FRONT_ROWS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_key),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  fma_ram #(.WIDTH(fma_pkg::VAL_W), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_addr),
    .rdata (val_rdata)
  );

  fma_fpadd u_fpadd (
    .clk   (clk),
    .rst   (rst),
    .start (add_start),
    .a     (val_rdata),
    .b     (add_value),
    .done  (add_done),
    .sum   (add_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd0;
      col_limit   <= 6'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fma_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        fma_pkg::CFG_PIVOT_COLS:  col_limit   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == CLR_END - CLR_W'(1)) begin
            clr_cnt <= '0;
            state   <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + CLR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            func       <= in_func;
            srch_key   <= in_key;
            add_value  <= in_value;
            last       <= s_tlast;
            val_row    <= row_ext[RA_W-1:0];
            val_col    <= col_ext[CA_W-1:0];
            res_value  <= 64'd0;
            first      <= '0;
            count      <= nrows;
            unique case (in_func)
              fma_pkg::FN_LOAD: begin
                res_status <= (row_ext >= ROWS_MAX) ? fma_pkg::ST_RANGE : fma_pkg::ST_OK;
                state      <= S_DONE;
              end
              fma_pkg::FN_SCATTER: begin
                priority if (col_ext >= ncols) begin
                  res_status <= fma_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else if (nrows == '0) begin
                  res_status <= fma_pkg::ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= fma_pkg::ST_OK;
                  state      <= S_SRCH;
                end
              end
              fma_pkg::FN_CONTRIB: begin
                priority if (col_ext >= ncols) begin
                  res_status <= fma_pkg::ST_EXTENDED;
                  state      <= S_DONE;
                end else if (row_ext >= nrows) begin
                  res_status <= fma_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status <= fma_pkg::ST_OK;
                  state      <= S_VRD;
                end
              end
              fma_pkg::FN_READ: begin
                if ((row_ext >= nrows) || (col_ext >= ncols)) begin
                  res_status <= fma_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  res_status <= fma_pkg::ST_OK;
                  state      <= S_VRD;
                end
              end
              fma_pkg::FN_CLEAR: begin
                res_status <= fma_pkg::ST_OK;
                clr_reply  <= 1'b1;
                state      <= S_CLEAR;
              end
              default: begin
                res_status <= fma_pkg::ST_RANGE;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          first <= first_next;
          count <= count_next;
          if (count_next == '0) state <= S_CHK;
        end
        S_CHK: begin
          if ((first < nrows) && (key_rdata == srch_key)) begin
            val_row <= first[RA_W-1:0];
            state   <= S_VRD;
          end else begin
            res_status <= fma_pkg::ST_NOT_FOUND;
            state      <= S_DONE;
          end
        end
        S_VRD: state <= S_VDATA;
        S_VDATA: begin
          if (func == fma_pkg::FN_READ) begin
            res_value <= val_rdata;
            state     <= S_DONE;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (add_done) begin
            res_value <= add_sum;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= res_value;
            m_tuser   <= res_status;
            m_tlast   <= last;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_we_only_in_write_states: assert property (@(posedge clk) disable iff (rst)
    val_we |-> (state == S_ADD) || (state == S_CLEAR))
    else $error("value ram written outside add or clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item taken while one is in work");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != fma_pkg::ST_OK) |-> (m_tdata == 64'd0))
    else $error("nonzero value with error status");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (count != '0))
    else $error("search step with empty range");
`endif

endmodule

// ===== dv/frontal_matrix_assembly_top_tb.sv =====
// ----------------------------------------------------------------------------
// frontal_matrix_assembly_top_tb
// self-checking bench for the frontal matrix store: a directed table covers
// boundary values, every operation and each error status, then random
// traffic runs under several row and column settings. an in-bench model of
// the key table and value store predicts the results not given in the
// directed table, and results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module frontal_matrix_assembly_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 64;
  localparam int COLS = 32;
  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;
  localparam logic [63:0] DBL_ONE     = 64'h3ff0_0000_0000_0000;
  localparam logic [63:0] DBL_NEG_TWO = 64'hc000_0000_0000_0000;
  localparam logic [63:0] DBL_MAX     = 64'h7fef_ffff_ffff_ffff;
  localparam logic [63:0] DBL_PINF    = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] DBL_NINF    = 64'hfff0_0000_0000_0000;
  localparam logic [63:0] DBL_NZERO   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DBL_SUB_MIN = 64'h0000_0000_0000_0001;
  localparam logic [63:0] DBL_SUB_MAX = 64'h000f_ffff_ffff_ffff;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [30:0] key;
    logic [63:0] val;
    logic        last;
  } fma_item_t;

  typedef struct packed {
    logic [63:0]      val;
    fma_pkg::status_t st;
    logic             last;
  } fma_result_t;

  typedef struct packed {
    fma_item_t        item;
    logic             typed;
    logic [63:0]      exp_val;
    fma_pkg::status_t exp_st;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [111:0]        s_tdata;
  logic [2:0]          s_tuser;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [63:0]         m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  fma_pkg::cfg_index_t cfg_index;
  logic [6:0]          cfg_data;

  frontal_matrix_assembly_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [30:0] key_table [ROWS];
  logic [63:0] front_store [ROWS*COLS];
  logic [6:0]  rows_reg;
  logic [5:0]  cols_reg;

  fma_result_t pending_results [$];
  int          errors;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("frontal_matrix_assembly_top_tb: FAIL");
    $finish;
  end

  function automatic int eff_rows();
    return (rows_reg > ROWS) ? ROWS : int'(rows_reg);
  endfunction

  function automatic int eff_cols();
    return (cols_reg > COLS) ? COLS : int'(cols_reg);
  endfunction

  function automatic logic [63:0] add_cell(int r, int c, logic [63:0] v);
    logic [63:0] sum;
    sum = $realtobits($bitstoreal(front_store[r*COLS+c]) + $bitstoreal(v));
    front_store[r*COLS+c] = sum;
    return sum;
  endfunction

  function automatic fma_result_t predict_result(fma_item_t it);
    fma_result_t res;
    int nr, nc, first, count, stp;
    nr = eff_rows();
    nc = eff_cols();
    res.val = '0;
    res.st = fma_pkg::ST_OK;
    res.last = it.last;
    case (it.func)
      fma_pkg::FN_LOAD: key_table[it.row] = it.key;
      fma_pkg::FN_SCATTER: begin
        if (it.col >= nc) begin
          res.st = fma_pkg::ST_RANGE;
        end else begin
          first = 0;
          count = nr;
          while (count > 0) begin
            stp = count / 2;
            if (key_table[first+stp] < it.key) begin
              first = first + stp + 1;
              count = count - stp - 1;
            end else begin
              count = stp;
            end
          end
          if (first < nr && key_table[first] == it.key)
            res.val = add_cell(first, it.col, it.val);
          else
            res.st = fma_pkg::ST_NOT_FOUND;
        end
      end
      fma_pkg::FN_CONTRIB: begin
        if (it.col >= nc) res.st = fma_pkg::ST_EXTENDED;
        else if (it.row >= nr) res.st = fma_pkg::ST_RANGE;
        else res.val = add_cell(it.row, it.col, it.val);
      end
      fma_pkg::FN_READ: begin
        if (it.row >= nr || it.col >= nc) res.st = fma_pkg::ST_RANGE;
        else res.val = front_store[it.row*COLS+it.col];
      end
      fma_pkg::FN_CLEAR: foreach (front_store[i]) front_store[i] = '0;
      default: res.st = fma_pkg::ST_RANGE;
    endcase
    return res;
  endfunction

  function automatic logic is_nan(logic [63:0] x);
    return x[62:52] == fma_pkg::EXP_MAX && x[51:0] != '0;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    fma_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (m_tuser != e.st)
          report_mismatch($sformatf("status %0d, expected %0d", m_tuser, e.st));
        if (m_tlast != e.last)
          report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, e.last));
        if (is_nan(e.val) ? !is_nan(m_tdata) : (m_tdata != e.val))
          report_mismatch($sformatf("value %h, expected %h", m_tdata, e.val));
      end
    end
  end

  // receiver stall pattern: phases of free flow, light and heavy backpressure
  initial begin
    int mode, left;
    m_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      left = $urandom_range(20, 120);
      repeat (left) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 9) < 7);
          default: m_tready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  task automatic send_item(fma_item_t it, logic typed = 1'b0,
                           logic [63:0] tv = '0, fma_pkg::status_t ts = fma_pkg::ST_OK);
    fma_result_t res;
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = it.func;
    s_tlast = it.last;
    s_tdata = {5'b0, it.val, it.key, it.col, it.row};
    do @(posedge clk); while (!s_tready);
    res = predict_result(it);
    if (typed) begin
      res.val = tv;
      res.st = ts;
    end
    pending_results.push_back(res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(fma_pkg::cfg_index_t idx, logic [6:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fma_pkg::CFG_ROWS_IN_USE) rows_reg = data;
    else cols_reg = data[5:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand_double();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return {$urandom, $urandom};
    return {1'($urandom), 11'($urandom_range(1000, 1050)), 20'($urandom), 32'($urandom)};
  endfunction

  function automatic fma_item_t make_item(logic [2:0] f, int r, int c, logic [30:0] k,
                                          logic [63:0] v, logic l);
    fma_item_t it;
    it.func = f;
    it.row = r[5:0];
    it.col = c[5:0];
    it.key = k;
    it.val = v;
    it.last = l;
    return it;
  endfunction

  // sorted keys spread over the whole key range
  task automatic load_sorted_keys();
    for (int i = 0; i < ROWS; i++)
      send_item(make_item(fma_pkg::FN_LOAD, i, $urandom,
                          (31'(i) << 25) | 31'($urandom_range(0, 33554431)),
                          rand_double(), (i == ROWS - 1)));
  endtask

  function automatic int pick_index(int n, int pct_in);
    if (n > 0 && $urandom_range(0, 99) < pct_in) return $urandom_range(0, n - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic fma_item_t random_item();
    int r, nr, nc;
    logic [30:0] k;
    nr = eff_rows();
    nc = eff_cols();
    r = $urandom_range(0, 99);
    k = 31'($urandom);
    if (r < 8)
      return make_item(fma_pkg::FN_LOAD, $urandom_range(0, 63), $urandom, k, rand_double(),
                       $urandom);
    if (r < 38) begin
      if (nr > 0 && $urandom_range(0, 3) != 0) k = key_table[$urandom_range(0, nr - 1)];
      return make_item(fma_pkg::FN_SCATTER, $urandom, pick_index(nc, 90), k, rand_double(),
                       $urandom);
    end
    if (r < 73)
      return make_item(fma_pkg::FN_CONTRIB, pick_index(nr, 90), pick_index(nc, 85), k,
                       rand_double(), $urandom);
    if (r < 97)
      return make_item(fma_pkg::FN_READ, pick_index(nr, 90), pick_index(nc, 90), k,
                       {$urandom, $urandom}, $urandom);
    if (r == 97)
      return make_item(fma_pkg::FN_CLEAR, $urandom, $urandom, k, rand_double(), $urandom);
    return make_item(3'($urandom_range(5, 7)), $urandom, $urandom, k, rand_double(), $urandom);
  endfunction

  initial begin
    dir_row_t directed [$];
    logic [6:0] phase_rows [8];
    logic [5:0] phase_cols [8];
    errors = 0;
    burst_left = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = fma_pkg::CFG_ROWS_IN_USE;
    cfg_data = '0;
    rows_reg = '0;
    cols_reg = '0;
    foreach (key_table[i]) key_table[i] = '0;
    foreach (front_store[i]) front_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(fma_pkg::CFG_ROWS_IN_USE, 7'd64);
    write_reg(fma_pkg::CFG_PIVOT_COLS, 7'd32);
    load_sorted_keys();

    directed = '{
      '{make_item(fma_pkg::FN_READ, 0, 0, 0, 0, 0), 1'b1, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_READ, 63, 31, 0, '1, 1), 1'b1, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_READ, 0, 32, 0, 0, 0), 1'b1, 64'd0, fma_pkg::ST_RANGE},
      '{make_item(fma_pkg::FN_CONTRIB, 0, 0, 0, DBL_ONE, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_CONTRIB, 63, 31, 0, DBL_MAX, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_CONTRIB, 5, 40, 0, DBL_ONE, 1), 1'b1, 64'd0,
        fma_pkg::ST_EXTENDED},
      '{make_item(fma_pkg::FN_CONTRIB, 5, 63, 0, DBL_ONE, 0), 1'b1, 64'd0,
        fma_pkg::ST_EXTENDED},
      '{make_item(fma_pkg::FN_LOAD, 0, 0, 31'd0, 0, 0), 1'b1, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_LOAD, 63, 0, 31'h7fff_ffff, 0, 1), 1'b1, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_SCATTER, 0, 0, 31'd0, DBL_NEG_TWO, 0), 1'b0, 64'd0,
        fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_SCATTER, 0, 31, 31'h7fff_ffff, DBL_MAX, 0), 1'b0, 64'd0,
        fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_SCATTER, 0, 3, 31'd5, DBL_ONE, 0), 1'b1, 64'd0,
        fma_pkg::ST_NOT_FOUND},
      '{make_item(fma_pkg::FN_SCATTER, 0, 32, 31'd0, DBL_ONE, 0), 1'b1, 64'd0,
        fma_pkg::ST_RANGE},
      '{make_item(fma_pkg::FN_SCATTER, 0, 63, 31'd0, DBL_ONE, 1), 1'b1, 64'd0,
        fma_pkg::ST_RANGE},
      '{make_item(fma_pkg::FN_CONTRIB, 1, 1, 0, DBL_PINF, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_CONTRIB, 1, 1, 0, DBL_NINF, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_CONTRIB, 2, 2, 0, DBL_SUB_MIN, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_CONTRIB, 2, 2, 0, DBL_SUB_MAX, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_CONTRIB, 3, 3, 0, DBL_NZERO, 0), 1'b0, 64'd0, fma_pkg::ST_OK},
      '{make_item(FN_SPARE_A, 0, 0, 0, 0, 0), 1'b1, 64'd0, fma_pkg::ST_RANGE},
      '{make_item(FN_SPARE_B, 0, 0, 0, 0, 1), 1'b1, 64'd0, fma_pkg::ST_RANGE},
      '{make_item(FN_SPARE_C, 63, 63, 31'h7fff_ffff, '1, 1), 1'b1, 64'd0, fma_pkg::ST_RANGE},
      '{make_item(fma_pkg::FN_CLEAR, 0, 0, 0, 0, 0), 1'b1, 64'd0, fma_pkg::ST_OK},
      '{make_item(fma_pkg::FN_READ, 1, 1, 0, 0, 0), 1'b1, 64'd0, fma_pkg::ST_OK}
    };
    foreach (directed[i])
      send_item(directed[i].item, directed[i].typed, directed[i].exp_val, directed[i].exp_st);

    phase_rows = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd37, 7'($urandom), 7'($urandom_range(1, 64)), 7'd64};
    phase_cols = '{6'd32, 6'd63, 6'd0, 6'd1, 6'd20, 6'($urandom), 6'($urandom_range(1, 32)), 6'd32};
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(fma_pkg::CFG_ROWS_IN_USE, phase_rows[p]);
      write_reg(fma_pkg::CFG_PIVOT_COLS, {1'b0, phase_cols[p]});
      if (p % 2 == 0) load_sorted_keys();
      repeat (52) send_item(random_item());
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("frontal_matrix_assembly_top_tb: PASS");
    end else begin
      $display("frontal_matrix_assembly_top_tb: FAIL");
    end
    $finish;
  end

endmodule
